@@ src/bfth_pkg.sv @@
// Shared constants, types and command/status structs for the three-hash bloom filter.
// No dependencies; imported by every module of the block except the checker bfth_chk.
package bfth_pkg;

    // Filter geometry
    localparam int FILTER_SIZE_LOG2 = 16;
    localparam int IDX_W            = FILTER_SIZE_LOG2;
    localparam int ROW_LOG2         = 3;
    localparam int ROW_W            = 1 << ROW_LOG2;
    localparam int ROW_AW           = IDX_W - ROW_LOG2;
    localparam int ROWS             = 1 << ROW_AW;

    // Hash constants; only the low IDX_W bits ever reach an index
    localparam logic [63:0] DJB_START  = 64'd5381;
    localparam logic [63:0] SDBM_START = 64'd0;
    localparam logic [63:0] FNV_START  = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;

    localparam logic [IDX_W-1:0] DJB_START_IDX  = DJB_START[IDX_W-1:0];
    localparam logic [IDX_W-1:0] SDBM_START_IDX = SDBM_START[IDX_W-1:0];
    localparam logic [IDX_W-1:0] FNV_START_IDX  = FNV_START[IDX_W-1:0];
    localparam logic [IDX_W-1:0] FNV_PRIME_IDX  = FNV_PRIME[IDX_W-1:0];

    localparam logic [7:0] FOLD_BIT  = 8'h20;
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // Index select codes
    localparam logic [1:0] SEL_DJB  = 2'd0;
    localparam logic [1:0] SEL_SDBM = 2'd1;
    localparam logic [1:0] SEL_FNV  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    // Controller -> hash datapath
    typedef struct packed {
        logic hash_step;   // absorb the accepted byte
        logic word_end;    // accepted byte is last: latch indices, reload
    } hash_cmd_t;

    // Controller -> bit store datapath
    typedef struct packed {
        logic       clear;     // clear one row, advance sweep
        logic       rd_en;     // read row of selected index
        logic       wr_en;     // write back row with selected bit set
        logic       hit_init;  // preset the all-bits-set flag
        logic       hit_en;    // fold selected bit into the flag
        logic [1:0] sel;       // which index
    } bits_cmd_t;

    // Bit store datapath -> controller
    typedef struct packed {
        logic clear_last;  // sweep is on its final row
        logic hit;         // all bits tested so far are set
    } bits_sts_t;

endpackage

@@ src/bfth_hash.sv @@
// Running djb2 / sdbm / FNV-1a hashes, kept at index width, plus latched word indices.
// Depends on bfth_pkg.
module bfth_hash
    import bfth_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  hash_cmd_t       cmd,
    input  logic [7:0]      char_byte,
    output idx_t [2:0]      word_idx
);

    idx_t djb_reg, djb_next;
    idx_t sdbm_reg, sdbm_next;
    idx_t fnv_reg, fnv_next;
    logic stop_reg, stop_next;
    idx_t [2:0] idx_reg;

    logic [IDX_W+7:0]   fold_ext;
    idx_t               b;
    logic               term;
    logic               hashing;
    idx_t               djb_new, sdbm_new, fnv_new;
    logic [2*IDX_W-1:0] fnv_prod;

    // Index bits depend only on lower bits of the 64-bit state, so
    // truncated arithmetic is exact here.
    always_comb
    begin
        fold_ext = {{IDX_W{1'b0}}, (char_byte | FOLD_BIT)};
        b        = fold_ext[IDX_W-1:0];
        term     = (char_byte == CHAR_NL) || (char_byte == CHAR_NUL);
        hashing  = !stop_reg && !term;

        djb_new  = (djb_reg << 5) + djb_reg + b;
        sdbm_new = b + (sdbm_reg << 6) + (sdbm_reg << 16) - sdbm_reg;
        fnv_prod = {{IDX_W{1'b0}}, (fnv_reg ^ b)} * {{IDX_W{1'b0}}, FNV_PRIME_IDX};
        fnv_new  = fnv_prod[IDX_W-1:0];

        djb_next  = hashing ? djb_new  : djb_reg;
        sdbm_next = hashing ? sdbm_new : sdbm_reg;
        fnv_next  = hashing ? fnv_new  : fnv_reg;
        stop_next = stop_reg || term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            djb_reg  <= DJB_START_IDX;
            sdbm_reg <= SDBM_START_IDX;
            fnv_reg  <= FNV_START_IDX;
            stop_reg <= 1'b0;
        end
        else if (cmd.hash_step)
        begin
            if (cmd.word_end)
            begin
                djb_reg  <= DJB_START_IDX;
                sdbm_reg <= SDBM_START_IDX;
                fnv_reg  <= FNV_START_IDX;
                stop_reg <= 1'b0;
            end
            else
            begin
                djb_reg  <= djb_next;
                sdbm_reg <= sdbm_next;
                fnv_reg  <= fnv_next;
                stop_reg <= stop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_step && cmd.word_end)
        begin
            idx_reg[SEL_DJB]  <= djb_next;
            idx_reg[SEL_SDBM] <= sdbm_next;
            idx_reg[SEL_FNV]  <= fnv_next;
        end
    end

    assign word_idx = idx_reg;

endmodule

@@ src/bfth_bits.sv @@
// Filter bit store: row memory, clear sweep, read-modify-write and hit flag.
// Depends on bfth_pkg.
module bfth_bits
    import bfth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bits_cmd_t   cmd,
    input  idx_t [2:0]  word_idx,
    output bits_sts_t   sts
);

    logic [ROW_W-1:0]    mem [ROWS];
    logic [ROW_W-1:0]    rdata_reg;
    logic [ROW_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                hit_reg, hit_next;

    idx_t                idx_sel;
    logic [ROW_AW-1:0]   row_sel;
    logic [ROW_LOG2-1:0] bit_sel;
    logic [ROW_AW-1:0]   waddr;
    logic [ROW_W-1:0]    wdata;
    logic [ROW_W-1:0]    bit_mask;

    always_comb
    begin
        case (cmd.sel)
            SEL_DJB:  idx_sel = word_idx[SEL_DJB];
            SEL_SDBM: idx_sel = word_idx[SEL_SDBM];
            SEL_FNV:  idx_sel = word_idx[SEL_FNV];
            default:  idx_sel = word_idx[SEL_DJB];
        endcase
        row_sel  = idx_sel[IDX_W-1:ROW_LOG2];
        bit_sel  = idx_sel[ROW_LOG2-1:0];
        bit_mask = {{(ROW_W-1){1'b0}}, 1'b1} << bit_sel;

        waddr = cmd.clear ? clr_cnt_reg : row_sel;
        wdata = cmd.clear ? '0 : (rdata_reg | bit_mask);

        clr_cnt_next = clr_cnt_reg + 1'b1;

        if (cmd.hit_init)
            hit_next = 1'b1;
        else if (cmd.hit_en)
            hit_next = hit_reg & rdata_reg[bit_sel];
        else
            hit_next = hit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en || cmd.clear)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rdata_reg <= mem[row_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_next;
            hit_reg <= hit_next;
        end
    end

    assign sts.clear_last = &clr_cnt_reg;
    assign sts.hit        = hit_reg;

endmodule

@@ src/bfth_ctrl.sv @@
// Controller: clear sweep, byte intake, three-index lookup sequence, result register.
// Depends on bfth_pkg.
module bfth_ctrl
    import bfth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        last_byte,
    input  logic        req_type,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        maybe_present,
    output hash_cmd_t   hash_cmd,
    output bits_cmd_t   bits_cmd,
    input  bits_sts_t   bits_sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_USE   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       check_reg, check_next;
    logic       out_valid_reg, out_valid_next;
    logic       present_reg, present_next;
    logic       accept;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        check_next     = check_reg;
        out_valid_next = out_valid_reg && out_stall;
        present_next   = present_reg;
        in_stall       = 1'b1;
        accept         = 1'b0;
        hash_cmd       = '0;
        bits_cmd       = '0;
        bits_cmd.sel   = sel_reg;

        case (state_reg)
            S_CLEAR:
            begin
                bits_cmd.clear = 1'b1;
                if (bits_sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall           = 1'b0;
                accept             = in_valid;
                hash_cmd.hash_step = accept;
                hash_cmd.word_end  = accept && last_byte;
                if (accept && last_byte)
                begin
                    bits_cmd.hit_init = 1'b1;
                    check_next        = req_type;
                    sel_next          = SEL_DJB;
                    state_next        = S_RD;
                end
            end
            S_RD:
            begin
                bits_cmd.rd_en = 1'b1;
                state_next     = S_USE;
            end
            S_USE:
            begin
                bits_cmd.hit_en = check_reg;
                bits_cmd.wr_en  = !check_reg;
                if (sel_reg == SEL_FNV)
                    state_next = check_reg ? S_DONE : S_IDLE;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    present_next   = bits_sts.hit;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sel_reg       <= SEL_DJB;
            check_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        present_reg <= present_next;
    end

    assign out_valid     = out_valid_reg;
    assign maybe_present = present_reg;

endmodule

@@ src/bloom_filter_three_hash.sv @@
// Between lookups a byte that is not last is taken every cycle. After a last byte the input stalls
// for an add (three read-write pairs on the bit store) and for a check (three reads, then the result
// register); a check waits longer, and its result is registered later, while out_stall holds.
// Reset: asynchronous, active low. A clearing pass over all 2^(FILTER_SIZE_LOG2-3) rows
// (8192 at the default size) zeroes the bit store one 8-bit row per cycle; input stalls.
// Depends on bfth_pkg, bfth_ctrl, bfth_hash, bfth_bits.
module bloom_filter_three_hash
    import bfth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // byte input transaction
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        last_byte,
    input  logic        req_type,

    // check result transaction
    output logic        out_valid,
    input  logic        out_stall,
    output logic        maybe_present
);

    hash_cmd_t  hash_cmd;
    bits_cmd_t  bits_cmd;
    bits_sts_t  bits_sts;
    idx_t [2:0] word_idx;

    // Controller: sequences the clear sweep, byte intake and the three
    // bit accesses at word end; owns the result register so a pending
    // result does not hold up intake of the next word.
    bfth_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .last_byte     (last_byte),
        .req_type      (req_type),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .maybe_present (maybe_present),
        .hash_cmd      (hash_cmd),
        .bits_cmd      (bits_cmd),
        .bits_sts      (bits_sts)
    );

    // Hash datapath: three running hashes, one byte per cycle while input is accepted. The final
    // indices are latched on the last byte and the hashes reload at once.
    bfth_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hash_cmd),
        .char_byte (char_byte),
        .word_idx  (word_idx)
    );

    // Bit store datapath: rows of 8 filter bits, registered read.
    // Add does read then write per index; check ANDs the read bits.
    bfth_bits u_bits (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (bits_cmd),
        .word_idx (word_idx),
        .sts      (bits_sts)
    );

endmodule

@@ src/bfth_chk.sv @@
// Port-level checker for the bloom filter top level, attached by bind.
// No package dependency.
module bfth_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_byte,
    input logic       last_byte,
    input logic       req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic       maybe_present
);

    // a byte inside a word is never followed by a stall of the input
    a_mid_word_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_byte |=> !in_stall)
        else $error("input stalled after a mid-word byte");

    // word end starts the bit access sequence
    a_word_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> in_stall)
        else $error("input not stalled after a last byte");

    // a new result only appears out of the lookup sequence
    a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while taking bytes");

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(maybe_present))
        else $error("result changed while stalled");

endmodule

bind bloom_filter_three_hash bfth_chk u_chk (.*);
